@@ src/cpd_pkg.sv @@
`default_nettype none

package cpd_pkg;

  localparam int unsigned MAX_DETECTIONS_DEF = 32;
  localparam int unsigned COORD_BITS_DEF     = 12;

  localparam int unsigned COUNT_BITS     = 6;
  localparam int unsigned SIZE_BITS      = 13;
  localparam int unsigned THR_BITS       = 8;
  localparam int unsigned CHAN_BITS      = 8;
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 13;
  localparam int unsigned QUEUE_DEPTH    = 4;

  // Saturation divider: numerator (sum - 3*min) * 255, denominator sum.
  localparam int unsigned NUM_BITS  = 18;
  localparam int unsigned DEN_BITS  = 10;
  localparam int unsigned QUOT_BITS = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BRIGHT_THR   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAT_THR      = 3'd3;

  localparam logic [SIZE_BITS-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [SIZE_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [THR_BITS-1:0]  BRIGHT_THR_RST   = 8'd150;
  localparam logic [THR_BITS-1:0]  SAT_THR_RST      = 8'd30;

  localparam logic [2:0] COLOR_NONE   = 3'd0;
  localparam logic [2:0] COLOR_RED    = 3'd1;
  localparam logic [2:0] COLOR_YELLOW = 3'd2;
  localparam logic [2:0] COLOR_GREEN  = 3'd4;

  localparam logic KIND_DETECTION = 1'b0;
  localparam logic KIND_SUMMARY   = 1'b1;

  localparam logic [CHAN_BITS-1:0] CHAN_HIGH = 8'd150;
  localparam logic [CHAN_BITS-1:0] CHAN_LOW  = 8'd100;

  localparam logic [15:0] LUMA_R = 16'd77;
  localparam logic [15:0] LUMA_G = 16'd150;
  localparam logic [15:0] LUMA_B = 16'd29;

  localparam logic [8:0] CONF_OFFSET = 9'd50;
  localparam logic [8:0] CONF_MAX    = 9'd255;

  typedef struct packed {
    logic [SIZE_BITS-1:0] frame_width;
    logic [SIZE_BITS-1:0] frame_height;
    logic [THR_BITS-1:0]  bright_thr;
    logic [THR_BITS-1:0]  sat_thr;
  } cfg_t;

  // One classified pixel handed from the front to the back.
  typedef struct packed {
    logic                  detect;
    logic                  frame_end;
    logic [7:0]            confidence;
    logic [2:0]            color;
    logic [COUNT_BITS-1:0] count;
  } rec_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } fe_state_e;

  typedef enum logic {
    BK_DETECT,
    BK_SUMMARY
  } bk_state_e;

  function automatic logic [2:0] classify(input logic [CHAN_BITS-1:0] r,
                                          input logic [CHAN_BITS-1:0] g,
                                          input logic [CHAN_BITS-1:0] b);
    logic [2:0] c;
    c = COLOR_NONE;
    if (r >= CHAN_HIGH && g < CHAN_LOW && b < CHAN_LOW) begin
      c = COLOR_RED;
    end else if (r >= CHAN_HIGH && g >= CHAN_HIGH && b < CHAN_LOW) begin
      c = COLOR_YELLOW;
    end else if (g >= CHAN_LOW && r < CHAN_HIGH && b < CHAN_HIGH) begin
      c = COLOR_GREEN;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/cpd_if.sv @@
`default_nettype none

interface cpd_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;

  modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                  input ready);
  modport sink (input valid, input pixel_red, input pixel_green, input pixel_blue,
                output ready);
endinterface

interface cpd_result_if #(
  parameter int unsigned COORD_BITS = cpd_pkg::COORD_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic                            result_kind;
  logic [COORD_BITS-1:0]           column;
  logic [COORD_BITS-1:0]           row;
  logic [7:0]                      confidence;
  logic [2:0]                      color_code;
  logic [cpd_pkg::COUNT_BITS-1:0]  detection_count;
  logic                            last_of_item;

  modport source (output valid, output result_kind, output column, output row,
                  output confidence, output color_code, output detection_count,
                  output last_of_item, input ready);
  modport sink (input valid, input result_kind, input column, input row,
                input confidence, input color_code, input detection_count,
                input last_of_item, output ready);
endinterface

interface cpd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [cpd_pkg::CFG_INDEX_BITS-1:0] index;
  logic [cpd_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/cpd_sat_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle, most significant first.
module cpd_sat_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [cpd_pkg::NUM_BITS-1:0]   numer_i,
  input  wire logic [cpd_pkg::DEN_BITS-1:0]   denom_i,
  output logic                                done_o,
  output logic [cpd_pkg::QUOT_BITS-1:0]       quot_o
);

  localparam int unsigned NB = cpd_pkg::NUM_BITS;
  localparam int unsigned DB = cpd_pkg::DEN_BITS;
  localparam int unsigned QB = cpd_pkg::QUOT_BITS;
  localparam int unsigned SB = $clog2(QB);

  logic [NB-1:0] rem_q, rem_d;
  logic [NB-1:0] div_q, div_d;
  logic [QB-1:0] quot_q, quot_d;
  logic [SB-1:0] step_q, step_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic          rem_ge;

  assign rem_ge = (rem_q >= div_q);

  always_comb begin
    rem_d  = rem_q;
    div_d  = div_q;
    quot_d = quot_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = numer_i;
      div_d  = NB'({denom_i, {(QB-1){1'b0}}});
      quot_d = '0;
      step_d = SB'(QB - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_ge) begin
        rem_d = rem_q - div_q;
      end
      quot_d = {quot_q[QB-2:0], rem_ge};
      div_d  = div_q >> 1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - SB'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

@@ src/cpd_front.sv @@
`default_nettype none

module cpd_front #(
  parameter int unsigned MAX_DETECTIONS = cpd_pkg::MAX_DETECTIONS_DEF,
  parameter int unsigned COORD_BITS     = cpd_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  cpd_pixel_if.sink                  pixel_i,
  input  wire cpd_pkg::cfg_t         cfg_i,
  input  wire logic                  full_i,
  output logic                       push_o,
  output cpd_pkg::rec_t              rec_o,
  output logic [COORD_BITS-1:0]      col_o,
  output logic [COORD_BITS-1:0]      row_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned CN = cpd_pkg::COUNT_BITS;
  localparam int unsigned VW = (CB + 1 > cpd_pkg::SIZE_BITS) ? CB + 1 : cpd_pkg::SIZE_BITS;
  localparam logic [VW-1:0] Span = VW'(2 ** CB);

  // Last index along one axis: a size of zero acts as one, a size beyond the
  // coordinate range acts as the full range.
  function automatic logic [CB-1:0] last_index(input logic [cpd_pkg::SIZE_BITS-1:0] v);
    logic [VW-1:0] ve;
    logic [VW-1:0] l;
    ve = VW'(v);
    if (ve == '0) begin
      l = '0;
    end else if (ve > Span) begin
      l = Span - VW'(1);
    end else begin
      l = ve - VW'(1);
    end
    return l[CB-1:0];
  endfunction

  cpd_pkg::fe_state_e state_q, state_d;

  logic [CB-1:0] col_cnt_q, col_cnt_d;
  logic [CB-1:0] row_cnt_q, row_cnt_d;
  logic [CN-1:0] found_q, found_d;

  logic [CB-1:0] col_q, row_q;
  logic [2:0]    color_q;
  logic          bright_q, zero_q, fend_q;

  logic                            accept;
  logic [CB-1:0]                   w_last, h_last;
  logic                            at_row_end, frame_end;
  logic [9:0]                      sum, min3, diff;
  logic [7:0]                      mn;
  logic [cpd_pkg::NUM_BITS-1:0]    numer;
  logic [15:0]                     luma_full;
  logic                            div_done;
  logic [cpd_pkg::QUOT_BITS-1:0]   quot;
  logic [7:0]                      sat;
  logic [8:0]                      conf_sum;
  logic                            detect, emit;
  logic [CN-1:0]                   count_next;

  // Per-pixel terms, taken at the accepting edge.
  always_comb begin
    mn = (pixel_i.pixel_red < pixel_i.pixel_green) ? pixel_i.pixel_red : pixel_i.pixel_green;
    if (pixel_i.pixel_blue < mn) begin
      mn = pixel_i.pixel_blue;
    end
    sum  = 10'(pixel_i.pixel_red) + 10'(pixel_i.pixel_green) + 10'(pixel_i.pixel_blue);
    min3 = 10'(mn) * 10'd3;
    diff = sum - min3;
    numer = {diff, 8'b0} - cpd_pkg::NUM_BITS'(diff);
    luma_full = 16'(pixel_i.pixel_red) * cpd_pkg::LUMA_R
              + 16'(pixel_i.pixel_green) * cpd_pkg::LUMA_G
              + 16'(pixel_i.pixel_blue) * cpd_pkg::LUMA_B;
  end

  assign w_last     = last_index(cfg_i.frame_width);
  assign h_last     = last_index(cfg_i.frame_height);
  assign at_row_end = (col_cnt_q >= w_last);
  assign frame_end  = at_row_end && (row_cnt_q >= h_last);

  cpd_sat_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .numer_i (numer),
    .denom_i (sum),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Decision once saturation is known.
  always_comb begin
    sat        = zero_q ? 8'd0 : quot;
    conf_sum   = 9'(sat) + cpd_pkg::CONF_OFFSET;
    detect     = bright_q && (sat > cfg_i.sat_thr) && (color_q != cpd_pkg::COLOR_NONE) &&
                 (found_q < CN'(MAX_DETECTIONS));
    emit       = detect || fend_q;
    count_next = found_q + CN'(detect);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cpd_pkg::FE_IDLE: begin
        if (pixel_i.valid) begin
          state_d = cpd_pkg::FE_DIV;
        end
      end
      cpd_pkg::FE_DIV: begin
        if (div_done) begin
          state_d = cpd_pkg::FE_PUSH;
        end
      end
      cpd_pkg::FE_PUSH: begin
        if (!emit || !full_i) begin
          state_d = cpd_pkg::FE_IDLE;
        end
      end
      default: state_d = cpd_pkg::FE_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    pixel_i.ready = 1'b0;
    push_o        = 1'b0;
    case (state_q)
      cpd_pkg::FE_IDLE: pixel_i.ready = 1'b1;
      cpd_pkg::FE_PUSH: push_o = emit && !full_i;
      default: ;
    endcase
  end

  assign accept = pixel_i.valid && pixel_i.ready;

  // Frame position and detection count.
  always_comb begin
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    found_d   = found_q;
    if (accept) begin
      if (frame_end) begin
        col_cnt_d = '0;
        row_cnt_d = '0;
      end else if (at_row_end) begin
        col_cnt_d = '0;
        row_cnt_d = row_cnt_q + CB'(1);
      end else begin
        col_cnt_d = col_cnt_q + CB'(1);
      end
    end
    if (state_q == cpd_pkg::FE_PUSH && state_d == cpd_pkg::FE_IDLE) begin
      found_d = fend_q ? '0 : count_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cpd_pkg::FE_IDLE;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      found_q   <= '0;
    end else begin
      state_q   <= state_d;
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q    <= col_cnt_q;
      row_q    <= row_cnt_q;
      color_q  <= cpd_pkg::classify(pixel_i.pixel_red, pixel_i.pixel_green,
                                    pixel_i.pixel_blue);
      bright_q <= (luma_full[15:8] > cfg_i.bright_thr);
      zero_q   <= (sum == '0);
      fend_q   <= frame_end;
    end
  end

  always_comb begin
    rec_o.detect     = detect;
    rec_o.frame_end  = fend_q;
    rec_o.confidence = (conf_sum > cpd_pkg::CONF_MAX) ? 8'hFF : conf_sum[7:0];
    rec_o.color      = color_q;
    rec_o.count      = count_next;
  end

  assign col_o = col_q;
  assign row_o = row_q;

endmodule

`default_nettype wire

@@ src/cpd_queue.sv @@
`default_nettype none

module cpd_queue #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = cpd_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == CW'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    fill_d = fill_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ src/cpd_back.sv @@
`default_nettype none

// Expands one classified pixel into its detection and/or summary items.
module cpd_back #(
  parameter int unsigned COORD_BITS = cpd_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  empty_i,
  input  wire cpd_pkg::rec_t         rec_i,
  input  wire logic [COORD_BITS-1:0] col_i,
  input  wire logic [COORD_BITS-1:0] row_i,
  output logic                       pop_o,
  cpd_result_if.source               result_o
);

  localparam int unsigned CN = cpd_pkg::COUNT_BITS;

  cpd_pkg::bk_state_e state_q, state_d;

  logic                  out_valid_q, out_valid_d;
  logic                  kind_q;
  logic [COORD_BITS-1:0] col_q, row_q;
  logic [7:0]            conf_q;
  logic [2:0]            color_q;
  logic [CN-1:0]         count_q;
  logic                  last_q;

  logic load, emit_summary;

  assign load = !empty_i && (!out_valid_q || result_o.ready);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cpd_pkg::BK_DETECT: begin
        if (load && rec_i.detect && rec_i.frame_end) begin
          state_d = cpd_pkg::BK_SUMMARY;
        end
      end
      cpd_pkg::BK_SUMMARY: begin
        if (load) begin
          state_d = cpd_pkg::BK_DETECT;
        end
      end
      default: state_d = cpd_pkg::BK_DETECT;
    endcase
  end

  // Outputs.
  always_comb begin
    emit_summary = 1'b1;
    case (state_q)
      cpd_pkg::BK_DETECT:  emit_summary = !rec_i.detect;
      cpd_pkg::BK_SUMMARY: emit_summary = 1'b1;
      default:             emit_summary = 1'b1;
    endcase
    pop_o = load && (emit_summary || !rec_i.frame_end);
  end

  assign out_valid_d = load ? 1'b1 : (result_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpd_pkg::BK_DETECT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      count_q <= rec_i.count;
      if (emit_summary) begin
        kind_q  <= cpd_pkg::KIND_SUMMARY;
        col_q   <= '0;
        row_q   <= '0;
        conf_q  <= '0;
        color_q <= cpd_pkg::COLOR_NONE;
        last_q  <= 1'b1;
      end else begin
        kind_q  <= cpd_pkg::KIND_DETECTION;
        col_q   <= col_i;
        row_q   <= row_i;
        conf_q  <= rec_i.confidence;
        color_q <= rec_i.color;
        last_q  <= !rec_i.frame_end;
      end
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.result_kind     = kind_q;
  assign result_o.column          = col_q;
  assign result_o.row             = row_q;
  assign result_o.confidence      = conf_q;
  assign result_o.color_code      = color_q;
  assign result_o.detection_count = count_q;
  assign result_o.last_of_item    = last_q;

endmodule

`default_nettype wire

@@ src/color_pixel_detector_core.sv @@
`default_nettype none

// Color pixel detector. Pixels arrive in raster order on pixel_i; each one is
// placed against the configured frame size, its luma and saturation are
// computed and it is classified as red, yellow or green. A bright, saturated,
// colored pixel gives a detection item on result_o (at most MAX_DETECTIONS per
// frame), and the last pixel of a frame gives a summary item carrying the
// frame's count, after its detection if it has one. The front end accepts a
// pixel, its bit-serial saturation divider yields one quotient bit per cycle,
// it sees the divider finish, and a pixel that gives an item is handed to a
// four-entry queue; the front end stalls only while it is full. The back end
// drains the queue through an output register, one item per cycle while
// result_o is ready. Configuration registers are written through cfg_i, which
// is always ready, and should be written only while no pixel is in flight.
module color_pixel_detector_core #(
  parameter int unsigned MAX_DETECTIONS = cpd_pkg::MAX_DETECTIONS_DEF,
  parameter int unsigned COORD_BITS     = cpd_pkg::COORD_BITS_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  cpd_pixel_if.sink    pixel_i,
  cpd_cfg_if.sink      cfg_i,
  cpd_result_if.source result_o
);

  localparam int unsigned QW = 2 * COORD_BITS + $bits(cpd_pkg::rec_t);

  cpd_pkg::cfg_t cfg_q, cfg_d;

  logic                  push, full, empty, pop;
  cpd_pkg::rec_t         f_rec, b_rec;
  logic [COORD_BITS-1:0] f_col, f_row, b_col, b_row;
  logic [QW-1:0]         q_wdata, q_rdata;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        cpd_pkg::REG_FRAME_WIDTH:  cfg_d.frame_width  = cfg_i.data;
        cpd_pkg::REG_FRAME_HEIGHT: cfg_d.frame_height = cfg_i.data;
        cpd_pkg::REG_BRIGHT_THR:   cfg_d.bright_thr   = cfg_i.data[7:0];
        cpd_pkg::REG_SAT_THR:      cfg_d.sat_thr      = cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= cpd_pkg::FRAME_WIDTH_RST;
      cfg_q.frame_height <= cpd_pkg::FRAME_HEIGHT_RST;
      cfg_q.bright_thr   <= cpd_pkg::BRIGHT_THR_RST;
      cfg_q.sat_thr      <= cpd_pkg::SAT_THR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cpd_front #(
    .MAX_DETECTIONS (MAX_DETECTIONS),
    .COORD_BITS     (COORD_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pixel_i (pixel_i),
    .cfg_i   (cfg_q),
    .full_i  (full),
    .push_o  (push),
    .rec_o   (f_rec),
    .col_o   (f_col),
    .row_o   (f_row)
  );

  assign q_wdata = {f_col, f_row, f_rec};

  cpd_queue #(
    .WIDTH (QW),
    .DEPTH (cpd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (q_rdata),
    .empty_o (empty)
  );

  assign b_col = q_rdata[QW-1 -: COORD_BITS];
  assign b_row = q_rdata[QW-1-COORD_BITS -: COORD_BITS];
  assign b_rec = q_rdata[$bits(cpd_pkg::rec_t)-1:0];

  cpd_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .rec_i    (b_rec),
    .col_i    (b_col),
    .row_i    (b_row),
    .pop_o    (pop),
    .result_o (result_o)
  );

  // The front end must never push into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !full)
    else $error("push into full queue");

  // A summary item closes the pixel and carries no color.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      result_o.valid && (result_o.result_kind == cpd_pkg::KIND_SUMMARY) |->
      result_o.last_of_item && (result_o.color_code == cpd_pkg::COLOR_NONE))
    else $error("malformed summary item");

  // A detection names exactly one color.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      result_o.valid && (result_o.result_kind == cpd_pkg::KIND_DETECTION) |->
      $onehot(result_o.color_code))
    else $error("detection without a single color");

  // The count never passes the per-frame limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      result_o.valid |->
      (result_o.detection_count <= cpd_pkg::COUNT_BITS'(MAX_DETECTIONS)))
    else $error("detection count above limit");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned IDLE_PERCENT  = 15;
  localparam int unsigned COORD_SPAN    = 1 << COORD_BITS_DEF;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic                      kind;
    logic [COORD_BITS_DEF-1:0] column;
    logic [COORD_BITS_DEF-1:0] row;
    logic [7:0]                confidence;
    logic [2:0]                color;
    logic [COUNT_BITS-1:0]     count;
    logic                      last;
  } report_t;

  logic clk_i;
  logic rst_ni;
  logic steady;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;

  pixel_t  pixel_q[$];
  report_t awaited_reports[$];
  pixel_t  next_pixel;

  // Shadow of the configuration, the frame position counters and the detection count.
  logic [SIZE_BITS-1:0]      cfg_width;
  logic [SIZE_BITS-1:0]      cfg_height;
  logic [THR_BITS-1:0]       cfg_bright;
  logic [THR_BITS-1:0]       cfg_sat;
  logic [COORD_BITS_DEF-1:0] col_cnt;
  logic [COORD_BITS_DEF-1:0] row_cnt;
  logic [COUNT_BITS-1:0]     found_cnt;

  cpd_pixel_if pix ();
  cpd_cfg_if cfg ();
  cpd_result_if #(.COORD_BITS(COORD_BITS_DEF)) res ();

  color_pixel_detector_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pixel_i (pix),
    .cfg_i   (cfg),
    .result_o(res)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic string show(input report_t r);
    return $sformatf("kind=%0d col=%0d row=%0d conf=%0d color=%0d count=%0d last=%0d",
                     r.kind, r.column, r.row, r.confidence, r.color, r.count, r.last);
  endfunction

  // A zero size behaves as one, and sizes past the coordinate range are clamped.
  function automatic int unsigned span_of(input logic [SIZE_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > COORD_SPAN) return COORD_SPAN;
    return v;
  endfunction

  function automatic void score_pixel(input pixel_t px);
    int unsigned eff_w, eff_h, luma, lowest, total, sat, conf;
    logic [2:0] hue;
    logic frame_done;
    report_t rep;
    eff_w = span_of(cfg_width);
    eff_h = span_of(cfg_height);
    luma = (77 * px.red + 150 * px.green + 29 * px.blue) >> 8;
    lowest = px.red;
    if (px.green < lowest) lowest = px.green;
    if (px.blue < lowest) lowest = px.blue;
    total = px.red + px.green + px.blue;
    sat = (total == 0) ? 0 : ((total - 3 * lowest) * 255) / total;

    hue = COLOR_NONE;
    if (px.red >= CHAN_HIGH && px.green < CHAN_LOW && px.blue < CHAN_LOW) begin
      hue = COLOR_RED;
    end else if (px.red >= CHAN_HIGH && px.green >= CHAN_HIGH && px.blue < CHAN_LOW) begin
      hue = COLOR_YELLOW;
    end else if (px.green >= CHAN_LOW && px.red < CHAN_HIGH && px.blue < CHAN_HIGH) begin
      hue = COLOR_GREEN;
    end

    frame_done = (col_cnt >= eff_w - 1) && (row_cnt >= eff_h - 1);

    if (luma > cfg_bright && sat > cfg_sat && hue != COLOR_NONE &&
        found_cnt < MAX_DETECTIONS_DEF) begin
      conf = sat + 50;
      if (conf > 255) conf = 255;
      found_cnt = found_cnt + 1;
      rep.kind = KIND_DETECTION;
      rep.column = col_cnt;
      rep.row = row_cnt;
      rep.confidence = conf[7:0];
      rep.color = hue;
      rep.count = found_cnt;
      rep.last = !frame_done;
      awaited_reports.push_back(rep);
    end

    if (frame_done) begin
      rep = '0;
      rep.kind = KIND_SUMMARY;
      rep.color = COLOR_NONE;
      rep.count = found_cnt;
      rep.last = 1'b1;
      awaited_reports.push_back(rep);
      col_cnt = '0;
      row_cnt = '0;
      found_cnt = '0;
    end else if (col_cnt >= eff_w - 1) begin
      col_cnt = '0;
      row_cnt = row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
  endfunction

  task automatic check_report(input report_t seen);
    report_t want;
    string bad;
    if (awaited_reports.size() == 0) begin
      report_mismatch({"unexpected item ", show(seen)});
      return;
    end
    want = awaited_reports.pop_front();
    bad = "";
    if (seen.kind !== want.kind) bad = {bad, " result_kind"};
    if (seen.column !== want.column) bad = {bad, " column"};
    if (seen.row !== want.row) bad = {bad, " row"};
    if (seen.confidence !== want.confidence) bad = {bad, " confidence"};
    if (seen.color !== want.color) bad = {bad, " color_code"};
    if (seen.count !== want.count) bad = {bad, " detection_count"};
    if (seen.last !== want.last) bad = {bad, " last_of_item"};
    if (bad != "") begin
      report_mismatch({"wrong", bad, ": got ", show(seen), " want ", show(want)});
    end
  endtask

  // Pixel driver: the prediction is made at the edge where the item is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix.valid <= 1'b0;
      pix.pixel_red <= '0;
      pix.pixel_green <= '0;
      pix.pixel_blue <= '0;
    end else begin
      if (pix.valid && pix.ready) begin
        score_pixel({pix.pixel_red, pix.pixel_green, pix.pixel_blue});
      end
      if (!pix.valid || pix.ready) begin
        if (pixel_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
          next_pixel = pixel_q.pop_front();
          pix.valid <= 1'b1;
          pix.pixel_red <= next_pixel.red;
          pix.pixel_green <= next_pixel.green;
          pix.pixel_blue <= next_pixel.blue;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with a randomly stalling ready.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        check_report({res.result_kind, res.column, res.row, res.confidence,
                      res.color_code, res.detection_count, res.last_of_item});
      end
      res.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  cfg_width = value;
      REG_FRAME_HEIGHT: cfg_height = value;
      REG_BRIGHT_THR:   cfg_bright = value[THR_BITS-1:0];
      REG_SAT_THR:      cfg_sat = value[THR_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic setup_frame(input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h,
                             input logic [THR_BITS-1:0] bright, input logic [THR_BITS-1:0] sat);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_BRIGHT_THR, {5'd0, bright});
    write_reg(REG_SAT_THR, {5'd0, sat});
  endtask

  // Lets everything drain, then covers pixels still inside the front end.
  task automatic settle();
    while (pixel_q.size() != 0 || pix.valid || awaited_reports.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void push_pixel(input int r, input int g, input int b);
    pixel_q.push_back({r[7:0], g[7:0], b[7:0]});
  endfunction

  // Mostly pixels inside one of the color classes, with some plain noise.
  function automatic pixel_t make_pixel();
    pixel_t px;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: px = {8'($urandom_range(150, 255)), 8'($urandom_range(0, 99)),
                          8'($urandom_range(0, 99))};
      5, 6, 7, 8, 9: px = {8'($urandom_range(150, 255)), 8'($urandom_range(150, 255)),
                          8'($urandom_range(0, 99))};
      10, 11, 12, 13, 14, 15, 16: px = {8'($urandom_range(0, 149)),
                                        8'($urandom_range(100, 255)),
                                        8'($urandom_range(0, 149))};
      default: px = 24'($urandom);
    endcase
    return px;
  endfunction

  function automatic logic [THR_BITS-1:0] pick_level(input int unsigned top);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return THR_BITS'($urandom_range(0, top));
    endcase
  endfunction

  task automatic random_pixels(input int unsigned count);
    repeat (count) pixel_q.push_back(make_pixel());
  endtask

  initial begin
    steady = 1'b0;
    rst_ni = 1'b0;
    pix.valid = 1'b0;
    pix.pixel_red = '0;
    pix.pixel_green = '0;
    pix.pixel_blue = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    res.ready = 1'b0;
    cfg_width = FRAME_WIDTH_RST;
    cfg_height = FRAME_HEIGHT_RST;
    cfg_bright = BRIGHT_THR_RST;
    cfg_sat = SAT_THR_RST;
    col_cnt = '0;
    row_cnt = '0;
    found_cnt = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: 4x2 frames with open thresholds, color class borders and extremes.
    setup_frame(13'd4, 13'd2, 8'd0, 8'd0);
    push_pixel(0, 0, 0);
    push_pixel(255, 255, 255);
    push_pixel(255, 0, 0);
    push_pixel(255, 255, 0);
    push_pixel(0, 255, 0);
    push_pixel(150, 99, 99);
    push_pixel(149, 100, 149);
    push_pixel(150, 150, 99);
    push_pixel(150, 100, 99);
    push_pixel(255, 149, 0);
    push_pixel(0, 0, 255);
    push_pixel(100, 255, 150);
    push_pixel(150, 255, 100);
    push_pixel(1, 1, 1);
    push_pixel(255, 255, 254);
    push_pixel(149, 255, 149);
    push_pixel(200, 10, 10);
    push_pixel(0, 100, 0);
    push_pixel(255, 98, 98);
    push_pixel(170, 200, 30);
    settle();

    for (int p = 0; p < 15; p++) begin
      case (p)
        // Oversized width and zero height; the frame stays open for the next phase.
        0: begin
          setup_frame(13'd8191, 13'd0, 8'd0, 8'd0);
          random_pixels(12);
        end
        // Shrinking the width while the column counter is past the new end.
        1: begin
          setup_frame(13'd3, 13'd2, pick_level(120), pick_level(100));
          random_pixels(60);
        end
        2: begin
          setup_frame(13'd0, 13'd8191, pick_level(120), pick_level(100));
          random_pixels(12);
        end
        // Enough detecting pixels per frame to hit the per-frame limit.
        3: begin
          steady <= 1'b1;
          setup_frame(13'd8, 13'd6, 8'd0, 8'd0);
          random_pixels(100);
        end
        4: begin
          steady <= 1'b0;
          setup_frame(13'd5, 13'd3, 8'd255, 8'd255);
          random_pixels(30);
        end
        5: begin
          setup_frame(13'd4096, 13'd1, pick_level(120), pick_level(100));
          random_pixels(20);
        end
        default: begin
          setup_frame(13'($urandom_range(0, 9)), 13'($urandom_range(0, 5)),
                      pick_level(140), pick_level(120));
          random_pixels(70);
        end
      endcase
      settle();
    end

    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/cpd_pkg.sv
src/cpd_if.sv
src/cpd_sat_div.sv
src/cpd_front.sv
src/cpd_queue.sv
src/cpd_back.sv
src/color_pixel_detector_core.sv
tb/sv/testbench.sv
